// ===== sv/htach_pkg.sv =====
// htach_pkg: shared widths, constants, register indexes and types of the
// hall period tachometer. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package htach_pkg;

   localparam int TIME_WIDTH_DEFAULT = 32;
   localparam int STAMP_W            = 32;
   localparam int PPR_W              = 7;
   localparam int TIMEOUT_W          = 32;
   localparam int SCALE_W            = 24;
   localparam int RPM_W              = 26;
   localparam int SPEED_W            = 32;
   localparam int DIVISOR_W          = RPM_W + PPR_W;
   localparam int PROD_W             = RPM_W + SCALE_W;
   localparam int CSR_INDEX_W        = 8;
   localparam int CSR_DATA_W         = 32;
   localparam int QUEUE_DEPTH        = 2;

   localparam logic [RPM_W-1:0] MINUTE_US = RPM_W'(60000000);

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_PPR        = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] CSR_TIMEOUT    = CSR_INDEX_W'(1);
   localparam logic [CSR_INDEX_W-1:0] CSR_MM_SCALE   = CSR_INDEX_W'(2);
   localparam logic [CSR_INDEX_W-1:0] CSR_CKMH_SCALE = CSR_INDEX_W'(3);

   // register reset values
   localparam logic [PPR_W-1:0]     PPR_RESET        = PPR_W'(4);
   localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET    = TIMEOUT_W'(250000);
   localparam logic [SCALE_W-1:0]   MM_SCALE_RESET   = SCALE_W'(214467);
   localparam logic [SCALE_W-1:0]   CKMH_SCALE_RESET = SCALE_W'(77209);

   typedef struct packed {
      logic [PPR_W-1:0]     pulses_per_rotation;
      logic [TIMEOUT_W-1:0] stall_timeout_us;
      logic [SCALE_W-1:0]   mm_per_s_scale;
      logic [SCALE_W-1:0]   centi_kmph_scale;
   } cfg_type;

   // one classified word handed from front to back
   typedef struct packed {
      logic                 stopped;
      logic                 do_div;
      logic [DIVISOR_W-1:0] divisor;
   } job_type;

endpackage

`default_nettype wire

// ===== sv/htach_if.sv =====
// Handshake channels of the hall period tachometer: request, response and
// register write. Depends on htach_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface htach_req_if;
   logic                          valid;
   logic                          ready;
   logic                          hall_edge;
   logic [htach_pkg::STAMP_W-1:0] time_us;

   modport source (output valid, output hall_edge, output time_us, input ready);
   modport sink   (input valid, input hall_edge, input time_us, output ready);
endinterface

interface htach_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [htach_pkg::RPM_W-1:0]   motor_rpm;
   logic [htach_pkg::SPEED_W-1:0] speed_mm_s;
   logic [htach_pkg::SPEED_W-1:0] speed_centi_kmph;
   logic                          stopped;

   modport source (output valid, output motor_rpm, output speed_mm_s,
                   output speed_centi_kmph, output stopped, input ready);
   modport sink   (input valid, input motor_rpm, input speed_mm_s,
                   input speed_centi_kmph, input stopped, output ready);
endinterface

interface htach_csr_if;
   logic                              valid;
   logic                              ready;
   logic [htach_pkg::CSR_INDEX_W-1:0] index;
   logic [htach_pkg::CSR_DATA_W-1:0]  data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== sv/htach_front.sv =====
// htach_front: accepts request words, keeps the pulse times and classifies
// each word into a division job. Depends on htach_pkg, htach_if.
`timescale 1ns / 1ps
`default_nettype none

module htach_front #(
   parameter int TIME_WIDTH = htach_pkg::TIME_WIDTH_DEFAULT
) (
   input  wire logic                clock,
   input  wire logic                reset,
   htach_req_if.sink                req,
   input  wire htach_pkg::cfg_type  cfg,
   input  wire logic                queue_full,
   output      logic                push,
   output      htach_pkg::job_type  job
);

   logic [TIME_WIDTH-1:0] last_ff, last_in;
   logic [TIME_WIDTH-1:0] prev_ff, prev_in;
   logic [63:0]           stamp_ext;
   logic [TIME_WIDTH-1:0] now;
   logic [TIME_WIDTH-1:0] interval;
   logic [TIME_WIDTH-1:0] gap;
   logic [63:0]           interval_ext;
   logic                  no_pulse;
   logic                  stall;
   logic                  stopped;

   assign req.ready = !queue_full;
   assign push      = req.valid && req.ready;

   always_comb begin
      stamp_ext    = 64'(req.time_us);
      now          = stamp_ext[TIME_WIDTH-1:0];
      last_in      = req.hall_edge ? now     : last_ff;
      prev_in      = req.hall_edge ? last_ff : prev_ff;
      interval     = last_in - prev_in;
      gap          = now - last_in;
      interval_ext = 64'(interval);
      no_pulse     = (last_in == '0) || (prev_in == '0);
      stall        = 64'(gap) > 64'(cfg.stall_timeout_us);
      stopped      = no_pulse || (interval == '0) || (cfg.pulses_per_rotation == '0) || stall;
      job.stopped  = stopped;
      // interval above one minute gives zero rpm without division
      job.do_div   = !stopped && (interval_ext <= 64'(htach_pkg::MINUTE_US));
      job.divisor  = htach_pkg::DIVISOR_W'(interval_ext[htach_pkg::RPM_W-1:0])
                   * htach_pkg::DIVISOR_W'(cfg.pulses_per_rotation);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_ff <= '0;
         prev_ff <= '0;
      end else if (push) begin
         last_ff <= last_in;
         prev_ff <= prev_in;
      end
   end

endmodule

`default_nettype wire

// ===== sv/htach_queue.sv =====
// htach_queue: short job queue between front and back.
// Depends on htach_pkg.
`timescale 1ns / 1ps
`default_nettype none

module htach_queue (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                push,
   input  wire htach_pkg::job_type  push_job,
   input  wire logic                pop,
   output      htach_pkg::job_type  head_job,
   output      logic                full,
   output      logic                empty
);

   localparam int PTR_W = (htach_pkg::QUEUE_DEPTH > 1) ? $clog2(htach_pkg::QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(htach_pkg::QUEUE_DEPTH + 1);

   htach_pkg::job_type entry_ff [htach_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_push, do_pop;

   function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
      bump = (p == PTR_W'(htach_pkg::QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
   endfunction

   assign full     = count_ff == CNT_W'(htach_pkg::QUEUE_DEPTH);
   assign empty    = count_ff == '0;
   assign head_job = entry_ff[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;

   always_comb begin
      wr_ptr_in = do_push ? bump(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? bump(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff + CNT_W'(do_push) - CNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(htach_pkg::QUEUE_DEPTH))
      else $error("queue count past depth");

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      full |-> !push)
      else $error("push into full queue");

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      empty |-> !pop)
      else $error("pop from empty queue");

endmodule

`default_nettype wire

// ===== sv/htach_back.sv =====
// htach_back: restoring divider for rpm, two speed multipliers, saturation
// and the response register. Depends on htach_pkg, htach_if.
`timescale 1ns / 1ps
`default_nettype none

module htach_back (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire htach_pkg::cfg_type  cfg,
   input  wire htach_pkg::job_type  head_job,
   input  wire logic                empty,
   output      logic                pop,
   htach_rsp_if.source              rsp
);

   localparam int RW    = htach_pkg::RPM_W;
   localparam int DW    = htach_pkg::DIVISOR_W;
   localparam int PW    = htach_pkg::PROD_W;
   localparam int SW    = htach_pkg::SPEED_W;
   localparam int CNT_W = $clog2(RW);

   typedef enum logic [1:0] {ST_IDLE, ST_DIV, ST_MUL, ST_DONE} state_type;

   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [RW-1:0]      acc_ff, acc_in;      // dividend in, quotient out
   logic [DW-1:0]      rem_ff, rem_in;
   logic [DW-1:0]      div_ff, div_in;
   logic               stop_ff, stop_in;
   logic [PW-1:0]      prod_mm_ff, prod_mm_in;
   logic [PW-1:0]      prod_ck_ff, prod_ck_in;
   logic               out_valid_ff, out_valid_in;
   logic [RW-1:0]      rpm_out_ff, rpm_out_in;
   logic [SW-1:0]      mm_out_ff, mm_out_in;
   logic [SW-1:0]      ck_out_ff, ck_out_in;
   logic               stop_out_ff, stop_out_in;
   logic [DW:0]        trial;
   logic               ge;
   logic               load;

   function automatic logic [SW-1:0] saturate(input logic [PW-1:0] p);
      saturate = (p[PW-1:SW+16] != '0) ? '1 : p[SW+15:16];
   endfunction

   assign rsp.valid            = out_valid_ff;
   assign rsp.motor_rpm        = rpm_out_ff;
   assign rsp.speed_mm_s       = mm_out_ff;
   assign rsp.speed_centi_kmph = ck_out_ff;
   assign rsp.stopped          = stop_out_ff;

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      acc_in       = acc_ff;
      rem_in       = rem_ff;
      div_in       = div_ff;
      stop_in      = stop_ff;
      prod_mm_in   = prod_mm_ff;
      prod_ck_in   = prod_ck_ff;
      rpm_out_in   = rpm_out_ff;
      mm_out_in    = mm_out_ff;
      ck_out_in    = ck_out_ff;
      stop_out_in  = stop_out_ff;
      pop          = 1'b0;
      load         = 1'b0;

      // one quotient bit per cycle
      trial = {rem_ff, acc_ff[RW-1]};
      ge    = trial >= {1'b0, div_ff};

      unique case (state_ff)
         ST_IDLE: begin
            if (!empty) begin
               pop     = 1'b1;
               div_in  = head_job.divisor;
               stop_in = head_job.stopped;
               rem_in  = '0;
               cnt_in  = CNT_W'(RW - 1);
               if (head_job.do_div) begin
                  acc_in   = htach_pkg::MINUTE_US;
                  state_in = ST_DIV;
               end else begin
                  acc_in   = '0;
                  state_in = ST_MUL;
               end
            end
         end
         ST_DIV: begin
            rem_in = ge ? DW'(trial - {1'b0, div_ff}) : trial[DW-1:0];
            acc_in = {acc_ff[RW-2:0], ge};
            cnt_in = cnt_ff - CNT_W'(1);
            if (cnt_ff == '0) begin
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            prod_mm_in = PW'(acc_ff) * PW'(cfg.mm_per_s_scale);
            prod_ck_in = PW'(acc_ff) * PW'(cfg.centi_kmph_scale);
            state_in   = ST_DONE;
         end
         ST_DONE: begin
            if (!out_valid_ff || rsp.ready) begin
               load        = 1'b1;
               rpm_out_in  = acc_ff;
               mm_out_in   = saturate(prod_mm_ff);
               ck_out_in   = saturate(prod_ck_ff);
               stop_out_in = stop_ff;
               state_in    = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      out_valid_in = load || (out_valid_ff && !rsp.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
      cnt_ff      <= cnt_in;
      acc_ff      <= acc_in;
      rem_ff      <= rem_in;
      div_ff      <= div_in;
      stop_ff     <= stop_in;
      prod_mm_ff  <= prod_mm_in;
      prod_ck_ff  <= prod_ck_in;
      rpm_out_ff  <= rpm_out_in;
      mm_out_ff   <= mm_out_in;
      ck_out_ff   <= ck_out_in;
      stop_out_ff <= stop_out_in;
   end

   a_stop_zero: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && stop_out_ff) |-> (rpm_out_ff == '0))
      else $error("stopped word with nonzero rpm");

   a_zero_speed: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && rpm_out_ff == '0) |-> (mm_out_ff == '0 && ck_out_ff == '0))
      else $error("speed without rpm");

   a_pop_idle: assert property (@(posedge clock) disable iff (reset)
      pop |=> (state_ff == ST_DIV || state_ff == ST_MUL))
      else $error("dequeue did not start a job");

endmodule

`default_nettype wire

// ===== sv/hall_period_tachometer_core.sv =====
// hall_period_tachometer_core: top level, register file and wiring of front,
// queue and back. Depends on htach_pkg, htach_if and the htach_* modules.
//
// Period tachometer with stall timeout. Each request word carries a
// microsecond timestamp and a hall-edge flag; every word returns one response
// word with motor rpm = 60000000 / (pulse interval * pulses_per_rotation),
// two road speeds (rpm times a Q16 scale, saturated to 32 bits) and a stopped
// flag set when rpm is forced to zero (fewer than two pulses, zero interval,
// zero pulses_per_rotation, or gap since the last pulse above the timeout).
// Pulse times wrap modulo 2^TIME_WIDTH. The front takes a request word in the
// cycle it is offered as long as the two-word job queue has room; the back
// works on one word at a time: for a word that needs division it dequeues it,
// runs the restoring divider at one quotient bit per cycle, multiplies, and
// loads the response register, waiting there while an earlier response has
// not been taken; a word whose rpm is zero by rule skips the divider.
// The back starts the next word while a response waits.
// Registers are written through the csr channel (ready is always high):
// 0 pulses_per_rotation, 1 stall_timeout_us, 2 mm_per_s_scale,
// 3 centi_kmph_scale; other indexes are ignored. Write them only while idle.
`timescale 1ns / 1ps
`default_nettype none

module hall_period_tachometer_core #(
   parameter int TIME_WIDTH = htach_pkg::TIME_WIDTH_DEFAULT
) (
   input wire logic    clock,
   input wire logic    reset,
   htach_req_if.sink   req_if,
   htach_rsp_if.source rsp_if,
   htach_csr_if.sink   csr_if
);

   htach_pkg::cfg_type cfg_ff;
   htach_pkg::job_type push_job;
   htach_pkg::job_type head_job;
   logic               push;
   logic               pop;
   logic               queue_full;
   logic               queue_empty;

   // register file
   assign csr_if.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pulses_per_rotation <= htach_pkg::PPR_RESET;
         cfg_ff.stall_timeout_us    <= htach_pkg::TIMEOUT_RESET;
         cfg_ff.mm_per_s_scale      <= htach_pkg::MM_SCALE_RESET;
         cfg_ff.centi_kmph_scale    <= htach_pkg::CKMH_SCALE_RESET;
      end else if (csr_if.valid) begin
         unique case (csr_if.index)
            htach_pkg::CSR_PPR:
               cfg_ff.pulses_per_rotation <= csr_if.data[htach_pkg::PPR_W-1:0];
            htach_pkg::CSR_TIMEOUT:
               cfg_ff.stall_timeout_us <= csr_if.data[htach_pkg::TIMEOUT_W-1:0];
            htach_pkg::CSR_MM_SCALE:
               cfg_ff.mm_per_s_scale <= csr_if.data[htach_pkg::SCALE_W-1:0];
            htach_pkg::CSR_CKMH_SCALE:
               cfg_ff.centi_kmph_scale <= csr_if.data[htach_pkg::SCALE_W-1:0];
            default: ;   // unknown index: no register
         endcase
      end
   end

   // front: pulse times and classification
   htach_front #(
      .TIME_WIDTH (TIME_WIDTH)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req_if),
      .cfg        (cfg_ff),
      .queue_full (queue_full),
      .push       (push),
      .job        (push_job)
   );

   // two-word job queue
   htach_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .head_job (head_job),
      .full     (queue_full),
      .empty    (queue_empty)
   );

   // back: divide, scale, respond
   htach_back u_back (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .head_job (head_job),
      .empty    (queue_empty),
      .pop      (pop),
      .rsp      (rsp_if)
   );

endmodule

`default_nettype wire
